FILE: rtl/lrs_pkg.sv
`default_nettype none
package lrs_pkg;
  localparam int MAX_KEYS   = 1024;
  localparam int KEY_BITS   = 32;
  localparam int DIGIT_BITS = 8;
  localparam int NUM_BINS   = 1 << DIGIT_BITS;
  localparam int NUM_PASSES = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int ADDR_W     = $clog2(MAX_KEYS);
  localparam int CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int BIN_W      = DIGIT_BITS;
  localparam int PASS_W     = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sorted_key;
    logic        final_res;
    logic        empty_res;
    logic        overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_COUNT, OP_PREFIX, OP_SCATTER, OP_READ
  } dp_op_t;

  // controller -> datapath
  typedef struct packed {
    dp_op_t            op;
    logic [ADDR_W-1:0] idx;
    logic [BIN_W-1:0]  bin;
    logic [PASS_W-1:0] pass;
    logic              src_b;
    logic [KEY_BITS-1:0] key;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KEY_BITS-1:0] rd_key;
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: rtl/lrs_datapath.sv
`default_nettype none
module lrs_datapath import lrs_pkg::*; (
  input  wire logic    clk,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts
);
  logic [KEY_BITS-1:0] buf_a [MAX_KEYS];
  logic [KEY_BITS-1:0] buf_b [MAX_KEYS];
  logic [CNT_W-1:0]    hist  [NUM_BINS];

  // Operations are two-phase: the controller issues a read (src key by idx),
  // then in the next cycle the matching count/scatter using the registered key.
  logic [KEY_BITS-1:0] rd_a_r, rd_b_r;
  logic [KEY_BITS-1:0] skey_r;
  logic [BIN_W-1:0]    sbin_r;
  logic                stage_r;
  logic                sc_r;
  logic [CNT_W-1:0]    hrd_r;
  logic [CNT_W-1:0]    total_r;
  logic [CNT_W-1:0]    hval;

  logic [KEY_BITS-1:0] src_key;
  logic [BIN_W-1:0]    dig;
  logic [BIN_W-1:0]    hrd_bin;
  assign src_key = cmd.src_b ? rd_b_r : rd_a_r;
  assign dig = BIN_W'(src_key >> (32'(cmd.pass) * DIGIT_BITS));
  assign sts.rd_key = src_key;
  // prefix consumes the count of the current bin: fetch the next one ahead
  assign hrd_bin = (cmd.op == OP_PREFIX) ? BIN_W'(cmd.bin + 1'b1) : cmd.bin;

  always_ff @(posedge clk) begin
    rd_a_r <= buf_a[cmd.idx];
    rd_b_r <= buf_b[cmd.idx];
    hval   <= hist[dig];
    if (cmd.op == OP_LOAD) buf_a[cmd.idx] <= cmd.key;
    unique case (cmd.op)
      OP_CLEAR: begin
        hist[cmd.bin] <= '0;
        total_r <= '0;
      end
      OP_PREFIX: begin
        hist[cmd.bin] <= total_r;
        total_r <= total_r + hrd_r;
      end
      default: ;
    endcase
    hrd_r <= hist[hrd_bin];
    // count/scatter: key registered first, then hist read into hval, then hist written
    stage_r <= (cmd.op == OP_COUNT) || (cmd.op == OP_SCATTER);
    sc_r    <= (cmd.op == OP_SCATTER);
    skey_r  <= src_key;
    sbin_r  <= dig;
    if (stage_r) begin
      hist[sbin_r] <= hval + 1'b1;
      if (sc_r) begin
        if (cmd.src_b) buf_a[ADDR_W'(hval)] <= skey_r;
        else           buf_b[ADDR_W'(hval)] <= skey_r;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lrs_ctrl.sv
`default_nettype none
module lrs_ctrl import lrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CNT_RD, S_CNT_UPD, S_CNT_WAIT, S_PREFIX, S_SC_RD,
    S_SC_UPD, S_SC_WAIT, S_POP_RD, S_POP_WAIT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r, rptr_r;
  logic [CNT_W-1:0]  i_r;
  logic [BIN_W-1:0]  bin_r;
  logic [PASS_W-1:0] pass_r;
  logic              src_b_r, sorted_r, ovf_r, open_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic [1:0]        w_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.pass  = pass_r;
    cmd.src_b = src_b_r;
    cmd.bin   = bin_r;
    cmd.idx   = ADDR_W'(i_r);
    cmd.key   = in_data.key;
    unique case (state_r)
      S_IDLE: begin
        cmd.idx = ADDR_W'(open_r ? count_r : '0);
        if (in_valid && in_ready && in_data.cmd == CMD_PUSH &&
            (open_r ? count_r : '0) != CNT_W'(MAX_KEYS)) cmd.op = OP_LOAD;
      end
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_CNT_UPD: cmd.op = OP_COUNT;
      S_PREFIX: cmd.op = OP_PREFIX;
      S_SC_UPD: cmd.op = OP_SCATTER;
      S_POP_RD: cmd.idx = ADDR_W'(rptr_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; rptr_r <= '0; sorted_r <= 1'b0;
      ovf_r <= 1'b0; open_r <= 1'b0; out_valid_r <= 1'b0; src_b_r <= 1'b0;
      i_r <= '0; bin_r <= '0; pass_r <= '0; w_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          if (in_data.cmd == CMD_PUSH) begin
            logic [CNT_W-1:0] c;
            c = open_r ? count_r : '0;
            if (!open_r) begin
              rptr_r <= '0; sorted_r <= 1'b0; ovf_r <= 1'b0;
            end
            open_r <= 1'b1;
            if (c != CNT_W'(MAX_KEYS)) c = c + 1'b1;
            else ovf_r <= 1'b1;
            count_r <= c;
            if (in_data.last) begin
              open_r <= 1'b0; pass_r <= '0; src_b_r <= 1'b0;
              bin_r <= '0; state_r <= S_CLEAR;
            end
          end else if (sorted_r && rptr_r < count_r) begin
            state_r <= S_POP_RD;
          end else begin
            out_r <= '{sorted_key: '0, final_res: 1'b0, empty_res: 1'b1,
                       overflow: ovf_r};
            out_valid_r <= 1'b1;
          end
        end
        S_CLEAR: begin
          bin_r <= bin_r + 1'b1;
          i_r <= '0;
          if (bin_r == BIN_W'(NUM_BINS - 1))
            state_r <= (count_r == '0) ? S_PREFIX : S_CNT_RD;
        end
        // each key steps through read, hist update and the S_CNT_WAIT settle wait
        S_CNT_RD:  state_r <= S_CNT_UPD;
        S_CNT_UPD: state_r <= S_CNT_WAIT;
        S_CNT_WAIT: begin
          if (w_r == 2'd1) begin
            w_r <= '0;
            i_r <= i_r + 1'b1;
            if (i_r + 1'b1 == count_r) begin
              state_r <= S_PREFIX; bin_r <= '0;
            end else state_r <= S_CNT_RD;
          end else w_r <= w_r + 1'b1;
        end
        S_PREFIX: begin
          bin_r <= bin_r + 1'b1;
          i_r <= '0;
          if (bin_r == BIN_W'(NUM_BINS - 1))
            state_r <= (count_r == '0) ? S_SC_WAIT : S_SC_RD;
        end
        S_SC_RD:  state_r <= S_SC_UPD;
        S_SC_UPD: state_r <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (w_r == 2'd1 || count_r == '0) begin
            w_r <= '0;
            i_r <= i_r + 1'b1;
            if (count_r == '0 || i_r + 1'b1 == count_r) begin
              src_b_r <= !src_b_r;
              bin_r <= '0;
              if (pass_r == PASS_W'(NUM_PASSES - 1)) begin
                sorted_r <= 1'b1; rptr_r <= '0; state_r <= S_IDLE;
              end else begin
                pass_r <= pass_r + 1'b1; state_r <= S_CLEAR;
              end
            end else state_r <= S_SC_RD;
          end else w_r <= w_r + 1'b1;
        end
        S_POP_RD: state_r <= S_POP_WAIT;
        S_POP_WAIT: begin
          out_r <= '{sorted_key: 32'(sts.rd_key),
                     final_res: (rptr_r + 1'b1 == count_r),
                     empty_res: 1'b0, overflow: ovf_r};
          out_valid_r <= 1'b1;
          rptr_r <= rptr_r + 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KEYS)) else $error("count beyond capacity");
  a_rptr: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_r |-> rptr_r <= count_r) else $error("read pointer past count");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("accepting with result pending");
endmodule
`default_nettype wire

FILE: rtl/lsd_radix_sort_u32_top.sv
// Channel | Ports                        | Payload
// input   | in_valid / in_ready          | in_data  (cmd, key, last)
// result  | out_valid / out_ready        | out_data (sorted_key, final_res,
//         |                              |           empty_res, overflow)
// Push is taken in S_IDLE. Pop goes through S_POP_RD and S_POP_WAIT on the buffer read port.
// Sort after last: 4 passes, each a clear and a prefix over the 256 bins and a count and
// a scatter over the N keys, paced per key by the histogram read-modify-write.
// Reset (rst_n, synchronous) clears control; key buffers start undefined.
// A waiting result blocks new input until it is taken.
`default_nettype none
module lsd_radix_sort_u32_top import lrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  lrs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cmd, .sts
  );

  lrs_datapath u_dp (.clk, .cmd, .sts);
endmodule
`default_nettype wire
